FILE: rtl/core/chebyshev_sin_cos_macros.svh
// Assertion macros for the sine/cosine evaluator checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef CHEBYSHEV_SIN_COS_MACROS_SVH
`define CHEBYSHEV_SIN_COS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define CSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/csc_pkg.sv
// Shared types, constants and arithmetic helpers for the sine/cosine evaluator.
// Holds the coefficient table, built at elaboration. No dependencies.
package csc_pkg;

  localparam int COEFF_COUNT = 7;
  localparam int COEFF_WIDTH = 32;
  localparam int ROM_DEPTH   = 16;
  localparam int ROM_HALF    = ROM_DEPTH / 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int NUM_STEPS   = COEFF_COUNT + 2;

  typedef logic signed [63:0] s64_t;
  typedef logic signed [COEFF_WIDTH-1:0] coef_t;
  typedef coef_t rom_t [ROM_DEPTH];

  localparam logic [31:0] TWO_OVER_PI_Q32  = 32'hA2F9836E;
  localparam s64_t        HALF_PI_Q59      = 64'sh0C90FDAA22168C23;
  localparam s64_t        FOUR_OVER_PI_Q62 = 64'sh517CC1B727220A95;
  localparam s64_t        PI_OVER_8_Q63    = 64'sh3243F6A8885A308D;
  localparam s64_t        ONE_Q60          = 64'sh1000000000000000;

  // Split 64x64 signed-magnitude product: four 32x32 partial products
  typedef struct packed {
    logic        neg;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pp_t;

  // Queue entry between front and back
  typedef struct packed {
    s64_t       s;
    logic [1:0] e;
  } fq_t;

  // Back pipeline payload
  typedef struct packed {
    s64_t       s;
    s64_t       y;
    s64_t       z;
    s64_t       d;
    s64_t       dd;
    logic [1:0] e;
  } bk_t;

  function automatic pp_t pp_gen(input s64_t a, input s64_t b);
    pp_t         r;
    logic [63:0] ua;
    logic [63:0] ub;
    ua    = a[63] ? (~a + 64'd1) : a;
    ub    = b[63] ? (~b + 64'd1) : b;
    r.neg = a[63] ^ b[63];
    r.p00 = ua[31:0]  * ub[31:0];
    r.p01 = ua[31:0]  * ub[63:32];
    r.p10 = ua[63:32] * ub[31:0];
    r.p11 = ua[63:32] * ub[63:32];
    return r;
  endfunction

  // Sum partials, round half away from zero, saturate, apply sign
  function automatic s64_t smul_fin(input pp_t p, input int sh);
    logic [127:0] acc;
    logic [127:0] m;
    logic [63:0]  mag;
    acc = {64'd0, p.p00} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0} + {p.p11, 64'd0};
    acc = acc + (128'd1 << (sh - 1));
    m   = acc >> sh;
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) begin
      mag = 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      mag = m[63:0];
    end
    return p.neg ? s64_t'(~mag + 64'd1) : s64_t'(mag);
  endfunction

  function automatic s64_t smul_c(input s64_t a, input s64_t b, input int sh);
    return smul_fin(pp_gen(a, b), sh);
  endfunction

  function automatic s64_t pow_h(input int ex);
    s64_t p;
    p = PI_OVER_8_Q63;
    for (int i = 1; i < ex; i++) begin
      p = smul_c(p, PI_OVER_8_Q63, 63);
    end
    return p;
  endfunction

  // Truncating division by a small positive divisor, shift and subtract
  function automatic longint cdiv(input longint x, input longint den);
    logic [63:0] ux;
    logic [63:0] ud;
    logic [63:0] rem;
    logic [63:0] qt;
    ux  = (x < 0) ? 64'(-x) : 64'(x);
    ud  = 64'(den);
    rem = '0;
    qt  = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], ux[b]};
      if (rem >= ud) begin
        rem   = rem - ud;
        qt[b] = 1'b1;
      end
    end
    return (x < 0) ? -longint'(qt) : longint'(qt);
  endfunction

  function automatic coef_t to_rom(input longint x);
    logic signed [63:0] t;
    int                 sh;
    sh = 65 - COEFF_WIDTH;
    t  = (x + (64'sd1 <<< (sh - 1))) >>> sh;
    return t[COEFF_WIDTH-1:0];
  endfunction

  // Bessel-series coefficients of the two even Chebyshev expansions
  function automatic rom_t gen_rom();
    rom_t   r;
    longint cs;
    longint ss;
    longint vc;
    longint vs;
    int     n;
    for (int k = 0; k < ROM_HALF; k++) begin
      cs = 0;
      ss = 0;
      for (int m = 0; m <= 10; m++) begin
        n = m + k;
        if (!(k == 0 && m == 0)) begin
          vc = pow_h(2 * n);
          vs = pow_h(2 * n + 1);
          for (int i = 2; i <= m; i++) begin
            vc = cdiv(vc, longint'(i));
            vs = cdiv(vs, longint'(i));
          end
          for (int i = 2; i <= m + 2 * k; i++) begin
            vc = cdiv(vc, longint'(i));
            vs = cdiv(vs, longint'(i));
          end
          vs = cdiv(vs, longint'(2 * n + 1));
          vc = vc * 2;
          vs = vs * 4;
          if (((k + m) & 1) != 0) begin
            cs = cs - vc;
            ss = ss - vs;
          end else begin
            cs = cs + vc;
            ss = ss + vs;
          end
        end
      end
      r[k]            = to_rom(ss);
      r[ROM_HALF + k] = to_rom(cs);
    end
    return r;
  endfunction

  localparam rom_t COEFF_ROM = gen_rom();

  function automatic s64_t coef_q60(input coef_t c);
    s64_t x;
    x = c;
    if (COEFF_WIDTH >= 62) begin
      return x >>> (COEFF_WIDTH - 62);
    end
    return x <<< (62 - COEFF_WIDTH);
  endfunction

  // Coefficient j of the sine (e0 = 0) or cosine (e0 = 1) table, in Q60
  function automatic s64_t coef_sel(input logic e0, input int j);
    logic [3:0] idx;
    idx = {e0, 3'(j)};
    return coef_q60(COEFF_ROM[idx]);
  endfunction

endpackage

FILE: rtl/core/csc_front.sv
// Front end: takes requests, scales the angle by 2/pi, picks the quadrant and
// forms the reduced angle. Depends on csc_pkg.
module csc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic signed [31:0] angle_i,
  output logic              push_o,
  output csc_pkg::fq_t      push_data_o,
  input  logic              full_i
);

  logic                f_vld_q;
  csc_pkg::s64_t       t_q;
  csc_pkg::s64_t       t_d;
  logic signed [31:0]  ang_q;
  logic                mode_q;
  logic                adv;
  csc_pkg::s64_t       q_full;
  logic signed [3:0]   q_r;
  csc_pkg::s64_t       qhp;
  csc_pkg::s64_t       s_d;
  logic [1:0]          e_d;

  assign adv        = !(f_vld_q && full_i);
  assign in_stall_o = f_vld_q && full_i;
  assign t_d        = angle_i * $signed({1'b0, csc_pkg::TWO_OVER_PI_Q32});

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (adv) begin
      f_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      t_q    <= t_d;
      ang_q  <= angle_i;
      mode_q <= mode_i;
    end
  end

  // Quadrant: round to nearest, ties to even
  always_comb begin
    q_full = (t_q + (64'sd1 <<< 59)) >>> 60;
    q_r    = q_full[3:0];
    if (t_q[59:0] == (60'd1 << 59) && q_full[0]) begin
      q_r = q_full[3:0] - 4'sd1;
    end
    qhp = csc_pkg::s64_t'(q_r) * csc_pkg::HALF_PI_Q59;
    s_d = (csc_pkg::s64_t'(ang_q) <<< 31) - qhp;
    e_d = q_r[1:0] + {1'b0, mode_q};
  end

  assign push_o        = f_vld_q && !full_i;
  assign push_data_o.s = s_d;
  assign push_data_o.e = e_d;

endmodule

FILE: rtl/core/csc_fifo.sv
// Short request queue between the front end and the evaluation pipeline.
// Depends on csc_pkg.
module csc_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  csc_pkg::fq_t wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output csc_pkg::fq_t rdata_o,
  output logic         empty_o
);

  localparam int PW = $clog2(csc_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(csc_pkg::FIFO_DEPTH + 1);

  csc_pkg::fq_t    mem_q [csc_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_q;
  logic [PW-1:0]   rd_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CW'(csc_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/core/csc_back.sv
// Evaluation pipeline: scaled remainder, Clenshaw recurrence, final combine,
// rounding and output register. Each multiply takes two stages. Depends on csc_pkg.
module csc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  csc_pkg::fq_t       rdata_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o
);

  localparam int N  = csc_pkg::COEFF_COUNT;
  localparam int NS = csc_pkg::NUM_STEPS;

  logic               en;
  logic               pp_v_q [NS];
  csc_pkg::bk_t       pp_d_q [NS];
  csc_pkg::pp_t       pp_p_q [NS];
  logic               fn_v_q [NS];
  csc_pkg::bk_t       fn_d_q [NS];
  logic               out_v_q;
  logic signed [31:0] value_q;
  csc_pkg::s64_t      v;
  csc_pkg::s64_t      rr;
  logic signed [31:0] val_d;

  assign en    = !(out_v_q && out_stall_i);
  assign pop_o = en && !empty_i;

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int SH = (k == 0) ? 61 : ((k < N) ? 59 : 60);
    logic          in_v;
    csc_pkg::bk_t  in_d;
    csc_pkg::s64_t op_a;
    csc_pkg::s64_t op_b;
    csc_pkg::s64_t rm;
    csc_pkg::bk_t  fn_d;

    // Stage input
    if (k == 0) begin : g_src
      always_comb begin
        in_v    = !empty_i;
        in_d    = '0;
        in_d.s  = rdata_i.s;
        in_d.e  = rdata_i.e;
      end
    end else begin : g_src
      assign in_v = fn_v_q[k-1];
      assign in_d = fn_d_q[k-1];
    end

    // Multiplier operands
    if (k == 0) begin : g_op
      assign op_a = in_d.s;
      assign op_b = csc_pkg::FOUR_OVER_PI_Q62;
    end else if (k == 1) begin : g_op
      assign op_a = in_d.y;
      assign op_b = in_d.y;
    end else if (k <= N) begin : g_op
      assign op_a = in_d.z;
      assign op_b = in_d.d;
    end else begin : g_op
      assign op_a = in_d.d;
      assign op_b = in_d.y;
    end

    // Partial product stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pp_v_q[k] <= 1'b0;
      end else if (en) begin
        pp_v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pp_d_q[k] <= in_d;
        pp_p_q[k] <= csc_pkg::pp_gen(op_a, op_b);
      end
    end

    // Finish: sum, round, then the step's update
    assign rm = csc_pkg::smul_fin(pp_p_q[k], SH);

    if (k == 0) begin : g_fin
      always_comb begin
        fn_d   = pp_d_q[k];
        fn_d.y = rm;
      end
    end else if (k == 1) begin : g_fin
      always_comb begin
        fn_d    = pp_d_q[k];
        fn_d.z  = rm - csc_pkg::ONE_Q60;
        fn_d.d  = csc_pkg::coef_sel(pp_d_q[k].e[0], N - 1);
        fn_d.dd = '0;
      end
    end else if (k < N) begin : g_fin
      always_comb begin
        fn_d    = pp_d_q[k];
        fn_d.d  = rm - pp_d_q[k].dd + csc_pkg::coef_sel(pp_d_q[k].e[0], N - k);
        fn_d.dd = pp_d_q[k].d;
      end
    end else if (k == N) begin : g_fin
      always_comb begin
        fn_d   = pp_d_q[k];
        fn_d.d = rm - pp_d_q[k].dd + (csc_pkg::coef_sel(pp_d_q[k].e[0], 0) >>> 1);
      end
    end else begin : g_fin
      // Odd quadrant code takes f+1, even takes f*y+s
      always_comb begin
        fn_d   = pp_d_q[k];
        fn_d.d = pp_d_q[k].e[0] ? (pp_d_q[k].d + csc_pkg::ONE_Q60)
                                : (rm + (pp_d_q[k].s <<< 1));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fn_v_q[k] <= 1'b0;
      end else if (en) begin
        fn_v_q[k] <= pp_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        fn_d_q[k] <= fn_d;
      end
    end
  end

  // Sign, round to Q2.30 and saturate
  always_comb begin
    v  = fn_d_q[NS-1].e[1] ? -fn_d_q[NS-1].d : fn_d_q[NS-1].d;
    rr = (v + (64'sd1 <<< 29)) >>> 30;
    if (rr > (64'sd1 <<< 30)) begin
      rr = 64'sd1 <<< 30;
    end else if (rr < -(64'sd1 <<< 30)) begin
      rr = -(64'sd1 <<< 30);
    end
    val_d = rr[31:0];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= fn_v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q <= val_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign value_o     = value_q;

endmodule

FILE: rtl/core/chebyshev_sin_cos.sv
// Path: input register, queue, back-end steps, output register, out_valid_o.
// Throughput: one request per cycle unless stalled; nine two-stage 64x64 multiply
// steps (built from 32x32 partial products) form the fully pipelined back end.
// A four-entry queue lets the front end take requests in output stalls until full.
// Reset clears all valid and queue state; the coefficient table is constant.
module chebyshev_sin_cos (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic signed [31:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o
);

  logic         push;
  logic         pop;
  logic         full;
  logic         empty;
  csc_pkg::fq_t wdata;
  csc_pkg::fq_t rdata;

  // Quadrant reduction
  csc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .angle_i     (angle_i),
    .push_o      (push),
    .push_data_o (wdata),
    .full_i      (full)
  );

  // Decoupling queue
  csc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rdata),
    .empty_o (empty)
  );

  // Series evaluation
  csc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rdata_i     (rdata),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

endmodule

FILE: rtl/core/csc_checker.sv
// Port-level checks for the sine/cosine evaluator, bound to the top level.
// Depends on chebyshev_sin_cos_macros.svh.
`include "chebyshev_sin_cos_macros.svh"

module csc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] value_o
);

  `CSC_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `CSC_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(value_o), "stalled result changed")
  `CSC_ASSERT_IMP(a_range, out_valid_o, (value_o <= 32'sd1073741824) && (value_o >= -32'sd1073741824), "result beyond one")
  `CSC_ASSERT_IMP(a_reset, $rose(rst_ni), !out_valid_o && !in_stall_o, "not idle after reset")

endmodule

bind chebyshev_sin_cos csc_checker u_csc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_o     (value_o)
);
